@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Fixed port field widths
    localparam int PRI_PORT_W = 16;
    localparam int TAG_PORT_W = 64;
    localparam int OCC_PORT_W = 5;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming request
        logic exec;   // apply request to the slots and load the result register
    } spq_cmd_t;

endpackage

@@ rtl/core/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: capture, execute, and result register handshake.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            res_valid,
    input  logic            res_stall,
    output spq_pkg::spq_cmd_t cmd
);
    import spq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   res_free;

    // result register can take a new value when empty or being drained
    assign res_free = !res_valid_reg || !res_stall;

    assign in_stall  = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;

    assign cmd.load = (state_reg == ST_IDLE) && in_valid;
    assign cmd.exec = (state_reg == ST_EXEC) && res_free;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (res_free)
                begin
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

@@ rtl/core/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot array with per-slot compare and shift, fill count, request
// capture and result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spq_pkg::spq_cmd_t               cmd,
    input  logic                            req_type,
    input  logic [spq_pkg::PRI_PORT_W-1:0]  entry_priority,
    input  logic [spq_pkg::TAG_PORT_W-1:0]  entry_tag,
    output logic                            out_valid,
    output logic [spq_pkg::PRI_PORT_W-1:0]  out_priority,
    output logic [spq_pkg::TAG_PORT_W-1:0]  out_tag,
    output logic [1:0]                      status,
    output logic [spq_pkg::OCC_PORT_W-1:0]  occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // captured request
    req_t                     req_type_reg;
    logic [PRIORITY_BITS-1:0] req_pri_reg;
    logic [TAG_BITS-1:0]      req_tag_reg;

    // slot storage, slot 0 is the head
    logic [PRIORITY_BITS-1:0] slot_pri_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      slot_tag_reg [QUEUE_DEPTH];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    // result register
    logic                     out_valid_reg;
    logic [PRI_PORT_W-1:0]    out_pri_reg;
    logic [TAG_PORT_W-1:0]    out_tag_reg;
    status_t                  status_reg;
    logic [OCC_PORT_W-1:0]    occ_reg;

    logic [31:0]              pri_in_wide;
    logic [31:0]              head_pri_wide;
    logic [31:0]              cnt_wide;
    logic                     full;
    logic                     empty;
    logic                     do_push;
    logic                     do_pop;
    logic [QUEUE_DEPTH-1:0]   ins;

    assign pri_in_wide   = 32'(entry_priority);
    assign head_pri_wide = 32'(slot_pri_reg[0]);
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    assign do_push = cmd.exec && (req_type_reg == REQ_PUSH) && !full;
    assign do_pop  = cmd.exec && (req_type_reg == REQ_POP) && !empty;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req_t'(req_type);
            req_pri_reg  <= pri_in_wide[PRIORITY_BITS-1:0];
            req_tag_reg  <= entry_tag[TAG_BITS-1:0];
        end
    end

    // ins[i]: slot i takes the new entry or the one below it. Monotone from
    // the insertion point up to the current count.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_slot
        logic                     below_cnt;
        logic                     at_cnt;
        logic                     ins_prev;
        logic [PRIORITY_BITS-1:0] pri_prev;
        logic [TAG_BITS-1:0]      tag_prev;
        logic [PRIORITY_BITS-1:0] pri_up;
        logic [TAG_BITS-1:0]      tag_up;

        assign below_cnt = (CNT_W'(i) < count_reg);
        assign at_cnt    = (CNT_W'(i) == count_reg);
        assign ins[i]    = (below_cnt && (slot_pri_reg[i] > req_pri_reg)) || at_cnt;

        if (i == 0)
        begin : g_first
            assign ins_prev = 1'b0;
            assign pri_prev = req_pri_reg;
            assign tag_prev = req_tag_reg;
        end
        else
        begin : g_rest
            assign ins_prev = ins[i-1];
            assign pri_prev = slot_pri_reg[i-1];
            assign tag_prev = slot_tag_reg[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign pri_up = slot_pri_reg[i];
            assign tag_up = slot_tag_reg[i];
        end
        else
        begin : g_mid
            assign pri_up = slot_pri_reg[i+1];
            assign tag_up = slot_tag_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (do_push)
            begin
                if (ins[i])
                begin
                    slot_pri_reg[i] <= ins_prev ? pri_prev : req_pri_reg;
                    slot_tag_reg[i] <= ins_prev ? tag_prev : req_tag_reg;
                end
            end
            else if (do_pop)
            begin
                slot_pri_reg[i] <= pri_up;
                slot_tag_reg[i] <= tag_up;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign cnt_wide = 32'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_valid_reg <= do_pop;
            out_pri_reg   <= do_pop ? head_pri_wide[PRI_PORT_W-1:0] : '0;
            out_tag_reg   <= do_pop ? TAG_PORT_W'(slot_tag_reg[0]) : '0;
            occ_reg       <= cnt_wide[OCC_PORT_W-1:0];
            if (req_type_reg == REQ_PUSH)
            begin
                status_reg <= full ? STATUS_FULL : STATUS_OK;
            end
            else
            begin
                status_reg <= empty ? STATUS_EMPTY : STATUS_OK;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_priority = out_pri_reg;
    assign out_tag      = out_tag_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

endmodule

@@ rtl/core/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held in sorted order; push inserts behind equal
// priorities, pop returns the head.
//
//   channel   handshake             fields
//   request   in_valid / in_stall   req_type, entry_priority, entry_tag
//   result    res_valid / res_stall out_valid, out_priority, out_tag,
//                                   status, occupancy
//
// Each request is first captured, then applied by the parallel compare
// and shift across all slots. One result per request, in request order.
// The result register lets the next request be captured while a result
// waits; a stalled result holds the next request in the execute step.
// Reset clears fill count and control state; slot contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [spq_pkg::PRI_PORT_W-1:0]  entry_priority,
    input  logic [spq_pkg::TAG_PORT_W-1:0]  entry_tag,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic                            out_valid,
    output logic [spq_pkg::PRI_PORT_W-1:0]  out_priority,
    output logic [spq_pkg::TAG_PORT_W-1:0]  out_tag,
    output logic [1:0]                      status,
    output logic [spq_pkg::OCC_PORT_W-1:0]  occupancy
);
    import spq_pkg::*;

    spq_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .TAG_BITS      (TAG_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .req_type       (req_type),
        .entry_priority (entry_priority),
        .entry_tag      (entry_tag),
        .out_valid      (out_valid),
        .out_priority   (out_priority),
        .out_tag        (out_tag),
        .status         (status),
        .occupancy      (occupancy)
    );

endmodule

@@ tb/sorted_priority_queue_checker.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_checker
// Watches the request and result channels of the sorted priority queue,
// keeps its own sorted copy of the stored entries, works out the reply to
// every accepted request and compares each accepted result against the
// oldest reply still outstanding.
// ----------------------------------------------------------------------------
module sorted_priority_queue_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            req_type,
    input  logic [spq_pkg::PRI_PORT_W-1:0]  entry_priority,
    input  logic [spq_pkg::TAG_PORT_W-1:0]  entry_tag,
    input  logic                            res_valid,
    input  logic                            res_stall,
    input  logic                            out_valid,
    input  logic [spq_pkg::PRI_PORT_W-1:0]  out_priority,
    input  logic [spq_pkg::TAG_PORT_W-1:0]  out_tag,
    input  logic [1:0]                      status,
    input  logic [spq_pkg::OCC_PORT_W-1:0]  occupancy,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    typedef struct {
        logic                   valid;
        logic [PRI_PORT_W-1:0]  pri;
        logic [TAG_PORT_W-1:0]  tag;
        status_t                st;
        logic [OCC_PORT_W-1:0]  occ;
    } queue_reply_t;

    // sorted copy of the stored entries, head first
    logic [PRI_PORT_W-1:0]  stored_pri[$];
    logic [TAG_PORT_W-1:0]  stored_tag[$];
    queue_reply_t           pending_replies[$];
    int                     misses = 0;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic queue_reply_t apply_request(req_t kind, logic [PRI_PORT_W-1:0] pri,
                                                   logic [TAG_PORT_W-1:0] tag);
        queue_reply_t r;
        int           pos;
        r.valid = 1'b0;
        r.pri   = '0;
        r.tag   = '0;
        r.st    = STATUS_OK;
        if (kind == REQ_PUSH)
        begin
            if (stored_pri.size() >= QUEUE_DEPTH)
                r.st = STATUS_FULL;
            else
            begin
                // goes behind every entry whose priority is not greater
                pos = stored_pri.size();
                for (int i = 0; i < stored_pri.size(); i++)
                begin
                    if (stored_pri[i] > pri)
                    begin
                        pos = i;
                        break;
                    end
                end
                stored_pri.insert(pos, pri);
                stored_tag.insert(pos, tag);
            end
        end
        else if (stored_pri.size() == 0)
            r.st = STATUS_EMPTY;
        else
        begin
            r.valid = 1'b1;
            r.pri   = stored_pri.pop_front();
            r.tag   = stored_tag.pop_front();
        end
        r.occ = OCC_PORT_W'(stored_pri.size());
        return r;
    endfunction

    function automatic int field_differs(string label, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, label, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_reply_t want;
        if (!rst_n)
        begin
            stored_pri.delete();
            stored_tag.delete();
            pending_replies.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                pending_replies.push_back(apply_request(req_t'(req_type), entry_priority,
                                                        entry_tag));
            if (res_valid && !res_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, got status %0h",
                             $time, status);
                    misses++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    misses += field_differs("out_valid", 64'(want.valid), 64'(out_valid));
                    misses += field_differs("out_priority", 64'(want.pri),
                                            64'(out_priority));
                    misses += field_differs("out_tag", 64'(want.tag), 64'(out_tag));
                    misses += field_differs("status", 64'(want.st), 64'(status));
                    misses += field_differs("occupancy", 64'(want.occ), 64'(occupancy));
                end
            end
            pending    <= pending_replies.size();
            fail_count <= misses;
        end
    end

endmodule

@@ tb/sorted_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Drives push and pop requests into the sorted priority queue: a directed
// opener covering empty pops, extreme priorities and tags and equal-priority
// ordering, a fill past capacity, then random phases that lean toward pushes
// or pops with wide or narrow priority ranges. Both channels idle at random;
// one phase back-pressures the result side until the input stalls, one
// drains the queue mid-run. The checker instance does all comparison.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int ITEM_TARGET = 1250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic                   clk;
    logic                   rst_n          = 1'b0;
    logic                   in_valid       = 1'b0;
    logic                   in_stall;
    logic                   req_type       = REQ_PUSH;
    logic [PRI_PORT_W-1:0]  entry_priority = '0;
    logic [TAG_PORT_W-1:0]  entry_tag      = '0;
    logic                   res_valid;
    logic                   res_stall      = 1'b0;
    logic                   out_valid;
    logic [PRI_PORT_W-1:0]  out_priority;
    logic [TAG_PORT_W-1:0]  out_tag;
    logic [1:0]             status;
    logic [OCC_PORT_W-1:0]  occupancy;

    int fail_count;
    int pending;
    int sent        = 0;
    int tx_idle_pct = 15;
    int rx_idle_pct = 15;
    int rx_hold_len = 0;
    int cycles      = 0;

    sorted_priority_queue i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .entry_priority (entry_priority),
        .entry_tag      (entry_tag),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .out_valid      (out_valid),
        .out_priority   (out_priority),
        .out_tag        (out_tag),
        .status         (status),
        .occupancy      (occupancy)
    );

    sorted_priority_queue_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .entry_priority (entry_priority),
        .entry_tag      (entry_tag),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .out_valid      (out_valid),
        .out_priority   (out_priority),
        .out_tag        (out_tag),
        .status         (status),
        .occupancy      (occupancy),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side: random stalls, or a long hold-off when one is requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len != 0)
            begin
                hold_left   = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold_left != 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // one request transfer; returns at the accepting edge
    task automatic send_request(req_t kind, logic [PRI_PORT_W-1:0] pri,
                                logic [TAG_PORT_W-1:0] tag);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= kind;
        entry_priority <= pri;
        entry_tag      <= tag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int count, int push_pct, bit narrow);
        logic [PRI_PORT_W-1:0] pri;
        logic [TAG_PORT_W-1:0] tag;
        req_t                  kind;
        repeat (count)
        begin
            case ($urandom_range(9))
                0:       pri = '0;
                1:       pri = '1;
                default: pri = narrow ? PRI_PORT_W'($urandom_range(3)) : PRI_PORT_W'($urandom);
            endcase
            tag  = {$urandom, $urandom};
            kind = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
            send_request(kind, pri, tag);
        end
    endtask

    initial
    begin
        int phase;
        int push_pct;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opener
        send_request(REQ_POP, '1, '1);
        send_request(REQ_PUSH, '0, '0);
        send_request(REQ_PUSH, '1, '1);
        send_request(REQ_PUSH, '1, 64'h1);
        send_request(REQ_PUSH, '0, 64'h5);
        send_request(REQ_PUSH, 16'h8000, 64'h8000_0000_0000_0000);
        send_request(REQ_PUSH, 16'h7fff, 64'h7fff_ffff_ffff_ffff);
        repeat (7) send_request(REQ_POP, '0, '0);

        // fill past capacity, then empty it again
        random_phase(18, 100, 1'b0);
        random_phase(18, 0, 1'b0);

        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            phase++;
            tx_idle_pct = (phase >= 10 && phase <= 14) ? 0 : 15;
            rx_idle_pct = tx_idle_pct;
            if (phase == 4)
            begin
                // result side blocked while requests keep coming
                rx_hold_len = HOLD_CYCLES;
                random_phase(40, 70, 1'b1);
            end
            else if (phase == 8)
                wait_drained();
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 15;
            endcase
            random_phase(50, push_pct, 1'($urandom_range(1)));
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
